### rtl/core/uida_pkg.sv
// Shared types and codes for the unique ID allocator.
`timescale 1ns / 1ps
package uida_pkg;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RESERVE = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ROW_HOLD,
		ROW_REMOVE,
		ROW_APPEND,
		ROW_ROTATE,
		ROW_CLEAR
	} row_op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_RIGHT,
		CELL_WRAP,
		CELL_KEY
	} cell_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC_POP,
		ST_ALLOC_SCAN,
		ST_RESERVE,
		ST_RELEASE,
		ST_REL_SWEEP,
		ST_REL_FIN
	} state_t;

	localparam int unsigned OUT_ID_W   = 16;
	localparam int unsigned OUT_WIDE_W = 17;

endpackage

### rtl/core/uida_cell.sv
// One list cell: a stored ID that loads from its neighbor, the wrap tap or the key.
`timescale 1ns / 1ps
module uida_cell #(
	parameter int unsigned W = 16
) (
	input  logic                clk,
	input  uida_pkg::cell_sel_t sel,
	input  logic [W-1:0]        right,
	input  logic [W-1:0]        wrap,
	input  logic [W-1:0]        key,
	output logic [W-1:0]        value,
	output logic                match
);

	logic [W-1:0] value_q;

	always_ff @(posedge clk) begin
		case (sel)
			uida_pkg::CELL_RIGHT: value_q <= right;
			uida_pkg::CELL_WRAP:  value_q <= wrap;
			uida_pkg::CELL_KEY:   value_q <= key;
			default:              value_q <= value_q;
		endcase
	end

	assign value = value_q;
	assign match = (value_q == key);

endmodule

### rtl/core/uida_row.sv
// Ordered row of ID cells with fill count, search, remove, append, rotate and clear.
`timescale 1ns / 1ps
module uida_row #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned W     = 16,
	localparam int unsigned CW   = $clog2(DEPTH + 1),
	localparam int unsigned PW   = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  uida_pkg::row_op_t op,
	input  logic [PW-1:0]     pos,
	input  logic [W-1:0]      key,
	output logic              hit,
	output logic [PW-1:0]     hit_pos,
	output logic [W-1:0]      head,
	output logic [CW-1:0]     count,
	output logic              full
);

	logic [CW-1:0]          count_q;
	logic [W-1:0]           val [DEPTH];
	logic [DEPTH-1:0]       match;
	logic [DEPTH-1:0]       hits;
	uida_pkg::cell_sel_t    sel [DEPTH];
	logic [CW-1:0]          last;

	assign last = count_q - CW'(1);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [W-1:0] right_v;
		if (i == DEPTH - 1) begin : g_end
			assign right_v = val[i];
		end else begin : g_mid
			assign right_v = val[i+1];
		end

		always_comb begin
			sel[i] = uida_pkg::CELL_HOLD;
			case (op)
				uida_pkg::ROW_REMOVE: begin
					if (CW'(i) >= CW'(pos) && CW'(i) < last && count_q != '0)
						sel[i] = uida_pkg::CELL_RIGHT;
				end
				uida_pkg::ROW_APPEND: begin
					if (CW'(i) == count_q)
						sel[i] = uida_pkg::CELL_KEY;
				end
				uida_pkg::ROW_ROTATE: begin
					if (count_q != '0) begin
						if (CW'(i) < last)
							sel[i] = uida_pkg::CELL_RIGHT;
						else if (CW'(i) == last)
							sel[i] = uida_pkg::CELL_WRAP;
					end
				end
				default: sel[i] = uida_pkg::CELL_HOLD;
			endcase
		end

		uida_cell #(.W(W)) u_cell (
			.clk   (clk),
			.sel   (sel[i]),
			.right (right_v),
			.wrap  (val[0]),
			.key   (key),
			.value (val[i]),
			.match (match[i])
		);

		assign hits[i] = match[i] && (CW'(i) < count_q);
	end

	always_comb begin
		hit_pos = '0;
		for (int j = DEPTH - 1; j >= 0; j--) begin
			if (hits[j])
				hit_pos = PW'(j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (op)
				uida_pkg::ROW_REMOVE: if (count_q != '0) count_q <= last;
				uida_pkg::ROW_APPEND: if (count_q != CW'(DEPTH)) count_q <= count_q + CW'(1);
				uida_pkg::ROW_CLEAR:  count_q <= '0;
				default:              count_q <= count_q;
			endcase
		end
	end

	assign hit   = |hits;
	assign head  = val[0];
	assign count = count_q;
	assign full  = (count_q == CW'(DEPTH));

endmodule

### rtl/core/unique_id_allocator.sv
// Top level of the unique ID allocator: request sequencer around two cell rows.
//
//  channel   | handshake           | fields
//  ----------+---------------------+----------------------------------------------
//  config    | cfg_wr_en           | cfg_wr_data (start_id)
//  request   | start & !busy       | req_type, id
//  result    | done (one cycle)    | result_id, ok, id_was_free, next_fresh, largest_seen
//
// Clear completes in the idle state. Allocate pops the free row, dropping popped entries
// that are reserved; once the free row is empty it falls back to the counter and skips
// reserved IDs. Release ends with a largest-ID sweep that rotates the reserved row one
// cell a cycle.
// Reset clears both row counts, the counter, the tracker and start_id; no clearing pass.
// Results leave through registers in the cycle after the last step; the receiver never stalls.
`timescale 1ns / 1ps
module unique_id_allocator #(
	parameter int unsigned FREE_DEPTH     = 64,
	parameter int unsigned RESERVED_DEPTH = 64,
	parameter int unsigned ID_WIDTH       = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] id,
	output logic        done,
	output logic [15:0] result_id,
	output logic        ok,
	output logic        id_was_free,
	output logic [16:0] next_fresh,
	output logic [16:0] largest_seen
);

	localparam int unsigned IW  = ID_WIDTH;
	localparam int unsigned FPW = $clog2(FREE_DEPTH);
	localparam int unsigned FCW = $clog2(FREE_DEPTH + 1);
	localparam int unsigned RPW = $clog2(RESERVED_DEPTH);
	localparam int unsigned RCW = $clog2(RESERVED_DEPTH + 1);

	uida_pkg::state_t  state_q, state_d;
	logic [15:0]       start_q;
	logic [IW-1:0]     id_q, id_d;
	logic [IW:0]       fresh_q, fresh_d;
	logic [IW:0]       largest_q, largest_d;
	logic              pend_ok_q, pend_ok_d;
	logic              was_free_q, was_free_d;
	logic [RCW-1:0]    sweep_q, sweep_d;
	logic              done_q;
	logic [15:0]       result_id_q;
	logic              ok_q;

	logic              emit, emit_ok;
	logic [IW-1:0]     emit_res;
	logic [31:0]       emit_res_ext, id_ext, start_ext, fresh_ext, largest_ext;
	logic [IW-1:0]     in_id, start_id_v;

	uida_pkg::row_op_t free_op, res_op;
	logic [FPW-1:0]    free_pos;
	logic [RPW-1:0]    res_pos;
	logic [IW-1:0]     free_key, res_key;
	logic              free_hit, free_full;
	logic [FPW-1:0]    free_hit_pos;
	logic [IW-1:0]     free_head;
	logic [FCW-1:0]    free_count;
	logic              res_hit, res_full;
	logic [RPW-1:0]    res_hit_pos;
	logic [IW-1:0]     res_head;
	logic [RCW-1:0]    res_count;

	assign id_ext     = 32'(id);
	assign in_id      = id_ext[IW-1:0];
	assign start_ext  = 32'(start_q);
	assign start_id_v = start_ext[IW-1:0];

	uida_row #(.DEPTH(FREE_DEPTH), .W(IW)) u_free (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (free_op),
		.pos     (free_pos),
		.key     (free_key),
		.hit     (free_hit),
		.hit_pos (free_hit_pos),
		.head    (free_head),
		.count   (free_count),
		.full    (free_full)
	);

	uida_row #(.DEPTH(RESERVED_DEPTH), .W(IW)) u_res (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (res_op),
		.pos     (res_pos),
		.key     (res_key),
		.hit     (res_hit),
		.hit_pos (res_hit_pos),
		.head    (res_head),
		.count   (res_count),
		.full    (res_full)
	);

	always_comb begin
		state_d    = state_q;
		id_d       = id_q;
		fresh_d    = fresh_q;
		largest_d  = largest_q;
		pend_ok_d  = pend_ok_q;
		was_free_d = was_free_q;
		sweep_d    = sweep_q;
		emit       = 1'b0;
		emit_ok    = 1'b1;
		emit_res   = '0;
		free_op    = uida_pkg::ROW_HOLD;
		free_pos   = free_hit_pos;
		free_key   = id_q;
		res_op     = uida_pkg::ROW_HOLD;
		res_pos    = res_hit_pos;
		res_key    = id_q;

		unique case (state_q)
			uida_pkg::ST_IDLE: begin
				free_key = in_id;
				if (start) begin
					id_d       = in_id;
					was_free_d = free_hit;
					unique case (uida_pkg::req_t'(req_type))
						uida_pkg::REQ_ALLOC:   state_d = uida_pkg::ST_ALLOC_POP;
						uida_pkg::REQ_RESERVE: state_d = uida_pkg::ST_RESERVE;
						uida_pkg::REQ_RELEASE: state_d = uida_pkg::ST_RELEASE;
						uida_pkg::REQ_CLEAR: begin
							fresh_d   = {1'b0, start_id_v};
							largest_d = '0;
							free_op   = uida_pkg::ROW_CLEAR;
							res_op    = uida_pkg::ROW_CLEAR;
							emit      = 1'b1;
						end
						default: state_d = uida_pkg::ST_IDLE;
					endcase
				end
			end
			uida_pkg::ST_ALLOC_POP: begin
				res_key  = free_head;
				free_pos = '0;
				if (free_count == '0) begin
					state_d = uida_pkg::ST_ALLOC_SCAN;
				end else begin
					free_op = uida_pkg::ROW_REMOVE;
					if (!res_hit) begin
						emit     = 1'b1;
						emit_res = free_head;
						if ({1'b0, free_head} > largest_q)
							largest_d = {1'b0, free_head};
						state_d = uida_pkg::ST_IDLE;
					end
				end
			end
			uida_pkg::ST_ALLOC_SCAN: begin
				res_key = fresh_q[IW-1:0];
				if (fresh_q[IW]) begin
					emit    = 1'b1;
					emit_ok = 1'b0;
					state_d = uida_pkg::ST_IDLE;
				end else if (res_hit) begin
					fresh_d = fresh_q + (IW+1)'(1);
				end else begin
					fresh_d  = fresh_q + (IW+1)'(1);
					emit     = 1'b1;
					emit_res = fresh_q[IW-1:0];
					if (fresh_q > largest_q)
						largest_d = fresh_q;
					state_d = uida_pkg::ST_IDLE;
				end
			end
			uida_pkg::ST_RESERVE: begin
				emit    = 1'b1;
				state_d = uida_pkg::ST_IDLE;
				if (res_hit) begin
					emit_ok = 1'b0;
				end else if ({1'b0, id_q} < fresh_q && !free_hit) begin
					emit_ok = 1'b0;
				end else if (res_full) begin
					emit_ok = 1'b0;
				end else begin
					if ({1'b0, id_q} < fresh_q)
						free_op = uida_pkg::ROW_REMOVE;
					res_op = uida_pkg::ROW_APPEND;
					if ({1'b0, id_q} > largest_q)
						largest_d = {1'b0, id_q};
				end
			end
			uida_pkg::ST_RELEASE: begin
				pend_ok_d = 1'b1;
				if ({1'b0, id_q} == largest_q)
					largest_d = '0;
				if (res_hit)
					res_op = uida_pkg::ROW_REMOVE;
				if ({1'b0, id_q} < fresh_q) begin
					if (free_full)
						pend_ok_d = 1'b0;
					else
						free_op = uida_pkg::ROW_APPEND;
				end
				sweep_d = '0;
				state_d = uida_pkg::ST_REL_SWEEP;
			end
			uida_pkg::ST_REL_SWEEP: begin
				if (sweep_q == res_count) begin
					state_d = uida_pkg::ST_REL_FIN;
				end else begin
					if ({1'b0, res_head} > largest_q)
						largest_d = {1'b0, res_head};
					res_op  = uida_pkg::ROW_ROTATE;
					sweep_d = sweep_q + RCW'(1);
				end
			end
			uida_pkg::ST_REL_FIN: begin
				free_key = fresh_q[IW-1:0];
				if (fresh_q > largest_q && !(free_hit && !fresh_q[IW]))
					largest_d = fresh_q;
				emit    = 1'b1;
				emit_ok = pend_ok_q;
				state_d = uida_pkg::ST_IDLE;
			end
			default: state_d = uida_pkg::ST_IDLE;
		endcase
	end

	assign emit_res_ext = 32'(emit_res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= uida_pkg::ST_IDLE;
			start_q   <= '0;
			fresh_q   <= '0;
			largest_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			if (cfg_wr_en)
				start_q <= cfg_wr_data;
			fresh_q   <= fresh_d;
			largest_q <= largest_d;
			done_q    <= emit;
		end
	end

	always_ff @(posedge clk) begin
		id_q       <= id_d;
		pend_ok_q  <= pend_ok_d;
		was_free_q <= was_free_d;
		sweep_q    <= sweep_d;
		if (emit) begin
			result_id_q <= emit_res_ext[15:0];
			ok_q        <= emit_ok;
		end
	end

	assign fresh_ext   = 32'(fresh_q);
	assign largest_ext = 32'(largest_q);

	assign busy         = (state_q != uida_pkg::ST_IDLE);
	assign done         = done_q;
	assign result_id    = result_id_q;
	assign ok           = ok_q;
	assign id_was_free  = was_free_q;
	assign next_fresh   = fresh_ext[16:0];
	assign largest_seen = largest_ext[16:0];

endmodule

### dv/unique_id_allocator_test.sv
// Self-checking testbench for the unique ID allocator: directed and random requests.
`timescale 1ns / 1ps
module unique_id_allocator_test;

	localparam int FREE_DEPTH = 64;
	localparam int RSV_DEPTH  = 64;
	localparam logic [16:0] ID_LIMIT = 17'h10000;

	typedef struct {
		logic [15:0] result_id;
		logic        ok;
		logic        id_was_free;
		logic [16:0] next_fresh;
		logic [16:0] largest_seen;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [15:0] id;
	logic        done;
	logic [15:0] result_id;
	logic        ok;
	logic        id_was_free;
	logic [16:0] next_fresh;
	logic [16:0] largest_seen;

	logic [15:0] free_list[$];
	logic [15:0] reserved_set[$];
	logic [16:0] fresh_ctr;
	logic [16:0] largest_id;
	logic [15:0] start_reg;
	answer_t     pending_answers[$];
	int          fail_count;

	unique_id_allocator uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.start(start), .busy(busy), .req_type(req_type), .id(id), .done(done),
		.result_id(result_id), .ok(ok), .id_was_free(id_was_free),
		.next_fresh(next_fresh), .largest_seen(largest_seen)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int free_pos(logic [15:0] v);
		foreach (free_list[i]) if (free_list[i] == v) return i;
		return -1;
	endfunction

	function automatic int reserved_pos(logic [15:0] v);
		foreach (reserved_set[i]) if (reserved_set[i] == v) return i;
		return -1;
	endfunction

	function automatic void raise_largest(logic [16:0] v);
		if (v > largest_id) largest_id = v;
	endfunction

	function automatic answer_t next_answer(uida_pkg::req_t r, logic [15:0] v);
		answer_t a;
		logic [16:0] cand;
		logic [15:0] popped;
		int pos;
		bit found;
		a.result_id = '0;
		a.ok = 1'b1;
		a.id_was_free = free_pos(v) >= 0;
		case (r)
			uida_pkg::REQ_ALLOC: begin
				found = 0;
				while (free_list.size() > 0 && !found) begin
					popped = free_list.pop_front();
					if (reserved_pos(popped) < 0) begin
						raise_largest({1'b0, popped});
						a.result_id = popped;
						found = 1;
					end
				end
				if (!found) begin
					cand = fresh_ctr;
					while (cand < ID_LIMIT && reserved_pos(cand[15:0]) >= 0) cand++;
					if (cand >= ID_LIMIT) begin
						fresh_ctr = ID_LIMIT;
						a.ok = 1'b0;
					end else begin
						fresh_ctr = cand + 17'd1;
						raise_largest(cand);
						a.result_id = cand[15:0];
					end
				end
			end
			uida_pkg::REQ_RESERVE: begin
				pos = -1;
				if (reserved_pos(v) >= 0) a.ok = 1'b0;
				else if ({1'b0, v} < fresh_ctr && free_pos(v) < 0) a.ok = 1'b0;
				else if (reserved_set.size() >= RSV_DEPTH) a.ok = 1'b0;
				else begin
					pos = free_pos(v);
					if (pos >= 0) free_list.delete(pos);
					raise_largest({1'b0, v});
					reserved_set.push_back(v);
				end
			end
			uida_pkg::REQ_RELEASE: begin
				if ({1'b0, v} == largest_id) largest_id = '0;
				pos = reserved_pos(v);
				if (pos >= 0) reserved_set.delete(pos);
				if ({1'b0, v} < fresh_ctr) begin
					if (free_list.size() < FREE_DEPTH) free_list.push_back(v);
					else a.ok = 1'b0;
				end
				foreach (reserved_set[i]) raise_largest({1'b0, reserved_set[i]});
				if (fresh_ctr > largest_id &&
				    (fresh_ctr >= ID_LIMIT || free_pos(fresh_ctr[15:0]) < 0))
					largest_id = fresh_ctr;
			end
			default: begin
				fresh_ctr = {1'b0, start_reg};
				largest_id = '0;
				free_list.delete();
				reserved_set.delete();
			end
		endcase
		a.next_fresh = fresh_ctr;
		a.largest_seen = largest_id;
		return a;
	endfunction

	task automatic send_req(uida_pkg::req_t r, logic [15:0] v, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			req_type = 2'($urandom);
			id = 16'($urandom);
		end
		@(negedge clk);
		start = 1'b1;
		req_type = r;
		id = v;
		do @(posedge clk); while (busy);
		pending_answers.push_back(next_answer(r, v));
	endtask

	task automatic set_start_id(logic [15:0] v);
		@(negedge clk);
		start = 1'b0;
		wait (pending_answers.size() == 0);
		repeat (80) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		start_reg = v;
	endtask

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected beat result_id=%h ok=%b", $time, result_id, ok);
				fail_count++;
			end else begin
				e = pending_answers.pop_front();
				if (result_id !== e.result_id) begin
					$display("%0t: result_id exp %h got %h", $time, e.result_id, result_id);
					fail_count++;
				end
				if (ok !== e.ok) begin
					$display("%0t: ok exp %b got %b", $time, e.ok, ok);
					fail_count++;
				end
				if (id_was_free !== e.id_was_free) begin
					$display("%0t: id_was_free exp %b got %b", $time, e.id_was_free,
						id_was_free);
					fail_count++;
				end
				if (next_fresh !== e.next_fresh) begin
					$display("%0t: next_fresh exp %h got %h", $time, e.next_fresh,
						next_fresh);
					fail_count++;
				end
				if (largest_seen !== e.largest_seen) begin
					$display("%0t: largest_seen exp %h got %h", $time, e.largest_seen,
						largest_seen);
					fail_count++;
				end
			end
		end
	end

	task automatic test_directed();
		set_start_id(16'd0);
		send_req(uida_pkg::REQ_ALLOC, 16'hFFFF, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'h0000, 0);
		send_req(uida_pkg::REQ_RESERVE, 16'd2, 0);
		send_req(uida_pkg::REQ_RESERVE, 16'd2, 0);
		send_req(uida_pkg::REQ_RESERVE, 16'd0, 0);
		send_req(uida_pkg::REQ_RESERVE, 16'hFFFF, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
		send_req(uida_pkg::REQ_RELEASE, 16'd0, 0);
		send_req(uida_pkg::REQ_RELEASE, 16'd0, 0);
		send_req(uida_pkg::REQ_RESERVE, 16'd0, 0);
		send_req(uida_pkg::REQ_RELEASE, 16'd1, 0);
		send_req(uida_pkg::REQ_RELEASE, 16'd1, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd1, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd1, 0);
		send_req(uida_pkg::REQ_RELEASE, 16'd500, 0);
		send_req(uida_pkg::REQ_RELEASE, 16'hFFFF, 0);
		send_req(uida_pkg::REQ_RELEASE, 16'd2, 0);
		send_req(uida_pkg::REQ_RELEASE, 16'd3, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
		send_req(uida_pkg::REQ_CLEAR, 16'h5A5A, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
	endtask

	task automatic test_exhaustion();
		set_start_id(16'hFFFE);
		send_req(uida_pkg::REQ_CLEAR, 16'd0, 0);
		send_req(uida_pkg::REQ_RESERVE, 16'hFFFF, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
		send_req(uida_pkg::REQ_RELEASE, 16'hFFFF, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'hFFFE, 0);
		set_start_id(16'hFFFF);
		send_req(uida_pkg::REQ_CLEAR, 16'd0, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
		send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
	endtask

	task automatic test_full_lists();
		set_start_id(16'd100);
		send_req(uida_pkg::REQ_CLEAR, 16'd0, 0);
		for (int i = 0; i < RSV_DEPTH + 2; i++)
			send_req(uida_pkg::REQ_RESERVE, 16'(200 + i), 0);
		for (int i = 0; i < 4; i++) send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
		for (int i = 0; i < FREE_DEPTH + 3; i++)
			send_req(uida_pkg::REQ_RELEASE, 16'(i % 90), 0);
		for (int i = 0; i < 10; i++) send_req(uida_pkg::REQ_RESERVE, 16'(i), 0);
		for (int i = 0; i < 70; i++) send_req(uida_pkg::REQ_ALLOC, 16'd0, 0);
	endtask

	task automatic test_random(int count, int idle_pct);
		logic [15:0] v;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if ($urandom_range(9) < 7) v = start_reg + 16'($urandom_range(90));
			else v = 16'($urandom);
			if (pick < 35) send_req(uida_pkg::REQ_ALLOC, v, idle_pct);
			else if (pick < 57) send_req(uida_pkg::REQ_RESERVE, v, idle_pct);
			else if (pick < 98) send_req(uida_pkg::REQ_RELEASE, v, idle_pct);
			else send_req(uida_pkg::REQ_CLEAR, v, idle_pct);
		end
	endtask

	initial begin
		fail_count = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		start = 1'b0;
		req_type = uida_pkg::REQ_ALLOC;
		id = '0;
		start_reg = '0;
		fresh_ctr = '0;
		largest_id = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_exhaustion();
		test_full_lists();
		set_start_id(16'd0);
		send_req(uida_pkg::REQ_CLEAR, 16'd0, 0);
		test_random(450, 0);
		set_start_id(16'($urandom));
		send_req(uida_pkg::REQ_CLEAR, 16'd0, 0);
		test_random(450, 74);
		set_start_id(16'hFFC0);
		send_req(uida_pkg::REQ_CLEAR, 16'd0, 0);
		test_random(450, 0);
		set_start_id(16'd40);
		send_req(uida_pkg::REQ_CLEAR, 16'd0, 0);
		test_random(400, 29);
		@(negedge clk);
		start = 1'b0;
		wait (pending_answers.size() == 0);
		repeat (150) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
rtl/core/uida_pkg.sv
rtl/core/uida_cell.sv
rtl/core/uida_row.sv
rtl/core/unique_id_allocator.sv
dv/unique_id_allocator_test.sv
